// ===== sv/sch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-Cookie parser package
// Parse phase type, field tags, attribute name table and character classes.
// ----------------------------------------------------------------------------
package sch_pkg;

  typedef enum logic [3:0] {
    PhLead   = 4'd0,
    PhName   = 4'd1,
    PhPreval = 4'd2,
    PhValue  = 4'd3,
    PhAfter  = 4'd4,
    PhAstart = 4'd5,
    PhAmatch = 4'd6,
    PhAvalue = 4'd7,
    PhSkip   = 4'd8
  } phase_e;

  // Field tags carried with each echoed byte.
  localparam logic [2:0] TagSkip    = 3'd0;
  localparam logic [2:0] TagName    = 3'd1;
  localparam logic [2:0] TagValue   = 3'd2;
  localparam logic [2:0] TagExpires = 3'd3;
  localparam logic [2:0] TagMaxAge  = 3'd4;
  localparam logic [2:0] TagDomain  = 3'd5;
  localparam logic [2:0] TagPath    = 3'd6;

  // Attribute codes, in table order.
  localparam logic [2:0] AttrExpires  = 3'd0;
  localparam logic [2:0] AttrMaxAge   = 3'd1;
  localparam logic [2:0] AttrDomain   = 3'd2;
  localparam logic [2:0] AttrPath     = 3'd3;
  localparam logic [2:0] AttrSecure   = 3'd4;
  localparam logic [2:0] AttrHttpOnly = 3'd5;
  localparam int unsigned NumAttr     = 6;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;

  // Lower-case attribute names, left aligned and padded with zero bytes.
  localparam logic [63:0] AttrName [NumAttr] = '{
    "expires=",
    "max-age=",
    {"domain=", 8'h00},
    {"path=", 24'h000000},
    {"secure", 16'h0000},
    "httponly"
  };

  localparam logic [3:0] AttrLen [NumAttr] = '{4'd8, 4'd8, 4'd7, 4'd5, 4'd6, 4'd8};

  function automatic logic [7:0] attr_char(input logic [2:0] k, input logic [2:0] p);
    logic [63:0] s;
    s = AttrName[k];
    return s[{~p, 3'b111} -: 8];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic alnum;
    alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39);
    return alnum || c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 ||
           c == 8'h26 || c == 8'h27 || c == 8'h2A || c == 8'h2B ||
           c == 8'h2D || c == 8'h2E || c == 8'h5E || c == 8'h5F ||
           c == 8'h60 || c == 8'h7C || c == 8'h7E;
  endfunction

  function automatic logic is_value(input logic [7:0] c);
    return c == 8'h21 || (c >= 8'h23 && c <= 8'h2B) ||
           (c >= 8'h2D && c <= 8'h3A) || (c >= 8'h3C && c <= 8'h5B) ||
           (c >= 8'h5D && c <= 8'h7E);
  endfunction

endpackage

// ===== sv/set_cookie_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-Cookie header parser
// Streams a Set-Cookie string one byte per beat and tags each byte.
// ----------------------------------------------------------------------------
// The block takes one byte per beat, with is_last_i on the final byte of a
// header string, and returns exactly one result beat per input beat: the byte
// echoed with the tag of the cookie field it belongs to (name, value, or the
// Expires, Max-Age, Domain and Path attribute values; zero for syntax bytes,
// skipped bytes and everything after a syntax error). The result beat for the
// last byte has done_res_o set and carries the parse status and the Secure and
// HttpOnly flags; these outputs read zero on every other beat, and all parser
// state returns to its reset value for the next cookie. One byte is accepted
// every cycle: a byte sits in an input register, a short block of character
// class and state logic decides its tag and the next parser state, and the
// result lands in an output register. The output register lets a new byte
// enter while a finished result still waits, and throughput drops only while
// the consumer holds out_ready_i low.
module set_cookie_header_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] echo_byte_o,
  output logic [2:0] field_tag_o,
  output logic       done_res_o,
  output logic       status_o,
  output logic       secure_flag_o,
  output logic       no_script_flag_o
);

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Output register.
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic [2:0] out_tag_q;
  logic       out_done_q;
  logic       out_status_q;
  logic       out_sec_q;
  logic       out_ho_q;

  // Parser state and its next value.
  sch_pkg::phase_e phase_q, phase_d;
  logic [3:0]      pos_q, pos_d;
  logic [2:0]      cand_q, cand_d;
  logic            quote_q, quote_d;
  logic            err_q, err_d;
  logic            sec_q, sec_d;
  logic            ho_q, ho_d;

  logic       advance;
  logic [7:0] lc;
  logic [2:0] match_k;
  logic [3:0] match_len;
  logic [3:0] match_p;
  logic [3:0] match_p_inc;
  logic       match_hit;
  logic [2:0] value_attr;
  logic [2:0] tag_raw;
  logic [2:0] tag;
  logic       bad;

  // The byte in the input register moves on whenever the output register is
  // free or is being emptied in this cycle.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign lc = sch_pkg::to_lower(in_byte_q);

  // Attribute name matcher: one character of the candidate name per byte.
  // An out-of-range candidate or position falls back to zero.
  assign match_k     = (cand_q < 3'(sch_pkg::NumAttr)) ? cand_q : sch_pkg::AttrExpires;
  assign match_len   = sch_pkg::AttrLen[match_k];
  assign match_p     = (pos_q < match_len) ? pos_q : 4'd0;
  assign match_p_inc = match_p + 4'd1;
  assign match_hit   = (lc == sch_pkg::attr_char(match_k, match_p[2:0]));

  // Only the four value-carrying attributes map onto their own tag.
  assign value_attr = (cand_q < sch_pkg::AttrSecure) ? cand_q : sch_pkg::AttrExpires;

  // Next-state logic for the parser.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    cand_d  = cand_q;
    quote_d = quote_q;
    err_d   = err_q;
    sec_d   = sec_q;
    ho_d    = ho_q;
    if (!err_q) begin
      case (phase_q)
        sch_pkg::PhLead: begin
          if (sch_pkg::is_token(in_byte_q)) begin
            phase_d = sch_pkg::PhName;
          end else if (!sch_pkg::is_blank(in_byte_q)) begin
            err_d = 1'b1;
          end
        end
        sch_pkg::PhName: begin
          if (sch_pkg::is_token(in_byte_q)) begin
            phase_d = phase_q;
          end else if (in_byte_q == sch_pkg::ChEqual) begin
            phase_d = sch_pkg::PhPreval;
          end else begin
            err_d = 1'b1;
          end
        end
        sch_pkg::PhPreval: begin
          if (sch_pkg::is_blank(in_byte_q)) begin
            phase_d = phase_q;
          end else if (in_byte_q == sch_pkg::ChQuote) begin
            quote_d = 1'b1;
            phase_d = sch_pkg::PhValue;
          end else if (sch_pkg::is_value(in_byte_q)) begin
            phase_d = sch_pkg::PhValue;
          end else if (in_byte_q == sch_pkg::ChSemi) begin
            phase_d = sch_pkg::PhAstart;
          end else begin
            err_d = 1'b1;
          end
        end
        sch_pkg::PhValue: begin
          if (sch_pkg::is_value(in_byte_q)) begin
            phase_d = phase_q;
          end else if (quote_q) begin
            if (in_byte_q == sch_pkg::ChQuote) begin
              quote_d = 1'b0;
              phase_d = sch_pkg::PhAfter;
            end else begin
              err_d = 1'b1;
            end
          end else if (sch_pkg::is_blank(in_byte_q)) begin
            phase_d = sch_pkg::PhAfter;
          end else if (in_byte_q == sch_pkg::ChSemi) begin
            phase_d = sch_pkg::PhAstart;
          end else begin
            err_d = 1'b1;
          end
        end
        sch_pkg::PhAfter: begin
          if (sch_pkg::is_blank(in_byte_q)) begin
            phase_d = sch_pkg::PhAfter;
          end else if (in_byte_q == sch_pkg::ChSemi) begin
            phase_d = sch_pkg::PhAstart;
          end else begin
            err_d = 1'b1;
          end
        end
        sch_pkg::PhAstart: begin
          if (!sch_pkg::is_blank(in_byte_q) && in_byte_q != sch_pkg::ChSemi) begin
            phase_d = sch_pkg::PhSkip;
            // Walk downward so the first name in the table wins.
            for (int k = sch_pkg::NumAttr - 1; k >= 0; k--) begin
              if (lc == sch_pkg::attr_char(3'(k), 3'd0)) begin
                cand_d  = 3'(k);
                pos_d   = 4'd1;
                phase_d = sch_pkg::PhAmatch;
              end
            end
          end
        end
        sch_pkg::PhAmatch: begin
          if (match_hit) begin
            pos_d = match_p_inc;
            if (match_p_inc >= match_len) begin
              if (match_k == sch_pkg::AttrSecure) begin
                sec_d   = 1'b1;
                phase_d = sch_pkg::PhAfter;
              end else if (match_k == sch_pkg::AttrHttpOnly) begin
                ho_d    = 1'b1;
                phase_d = sch_pkg::PhAfter;
              end else begin
                phase_d = sch_pkg::PhAvalue;
              end
            end
          end else if (in_byte_q == sch_pkg::ChSemi) begin
            phase_d = sch_pkg::PhAstart;
          end else begin
            phase_d = sch_pkg::PhSkip;
          end
        end
        sch_pkg::PhAvalue, sch_pkg::PhSkip: begin
          if (in_byte_q == sch_pkg::ChSemi) begin
            phase_d = sch_pkg::PhAstart;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  // Output logic: tag of the current byte and the end-of-string status.
  always_comb begin
    tag_raw = sch_pkg::TagSkip;
    case (phase_q)
      sch_pkg::PhLead, sch_pkg::PhName: begin
        if (sch_pkg::is_token(in_byte_q)) begin
          tag_raw = sch_pkg::TagName;
        end
      end
      sch_pkg::PhPreval, sch_pkg::PhValue: begin
        if (sch_pkg::is_value(in_byte_q)) begin
          tag_raw = sch_pkg::TagValue;
        end
      end
      sch_pkg::PhAvalue: begin
        if (in_byte_q != sch_pkg::ChSemi) begin
          tag_raw = sch_pkg::TagExpires + value_attr;
        end
      end
      default: begin
        tag_raw = sch_pkg::TagSkip;
      end
    endcase
    // Any error, old or raised by this byte, blanks the tag.
    tag = err_d ? sch_pkg::TagSkip : tag_raw;
    bad = err_d || (phase_d == sch_pkg::PhLead) || (phase_d == sch_pkg::PhName) ||
          ((phase_d == sch_pkg::PhValue) && quote_d) || (phase_d > sch_pkg::PhSkip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= text_byte_i;
      in_last_q <= is_last_i;
    end
  end

  // Parser state: the last byte of a string returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sch_pkg::PhLead;
      pos_q   <= 4'd0;
      cand_q  <= 3'd0;
      quote_q <= 1'b0;
      err_q   <= 1'b0;
      sec_q   <= 1'b0;
      ho_q    <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        phase_q <= sch_pkg::PhLead;
        pos_q   <= 4'd0;
        cand_q  <= 3'd0;
        quote_q <= 1'b0;
        err_q   <= 1'b0;
        sec_q   <= 1'b0;
        ho_q    <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        cand_q  <= cand_d;
        quote_q <= quote_d;
        err_q   <= err_d;
        sec_q   <= sec_d;
        ho_q    <= ho_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q   <= in_byte_q;
      out_tag_q    <= tag;
      out_done_q   <= in_last_q;
      out_status_q <= in_last_q && bad;
      out_sec_q    <= in_last_q && sec_d;
      out_ho_q     <= in_last_q && ho_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign echo_byte_o      = out_byte_q;
  assign field_tag_o      = out_tag_q;
  assign done_res_o       = out_done_q;
  assign status_o         = out_status_q;
  assign secure_flag_o    = out_sec_q;
  assign no_script_flag_o = out_ho_q;

endmodule

// ===== sv/sch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-Cookie parser port checker
// Watches the ports of the parser and checks beat accounting and outputs.
// ----------------------------------------------------------------------------
module sch_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] text_byte_i,
  input logic       is_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] echo_byte_o,
  input logic [2:0] field_tag_o,
  input logic       done_res_o,
  input logic       status_o,
  input logic       secure_flag_o,
  input logic       no_script_flag_o
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] occ_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // Beats taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 3'd0;
    end else if (in_beat && !out_beat) begin
      occ_q <= occ_q + 3'd1;
    end else if (!in_beat && out_beat) begin
      occ_q <= occ_q - 3'd1;
    end
  end

  // At most one byte in the input register and one in the output register.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd2)
    else $error("more beats in flight than the block can hold");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 3'd0)
    else $error("result beat without a matching input beat");

  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_tag_o <= sch_pkg::TagPath)
    else $error("field tag out of range");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (!status_o && !secure_flag_o && !no_script_flag_o))
    else $error("status or flags set on a beat that is not the last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(echo_byte_o) &&
                                       $stable(field_tag_o)))
    else $error("stalled result beat changed");

endmodule

bind set_cookie_header_parser sch_checker u_sch_checker (.*);

// ===== tb/sv/cookie_tag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-Cookie tag checker
// Predicts the tagged echo of every accepted byte and compares result beats.
// ----------------------------------------------------------------------------
module cookie_tag_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] text_byte_i,
  input  logic       is_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] echo_byte_i,
  input  logic [2:0] field_tag_i,
  input  logic       done_res_i,
  input  logic       status_i,
  input  logic       secure_flag_i,
  input  logic       no_script_flag_i,
  output int         pending_o,
  output int         mismatch_o
);

  typedef struct packed {
    logic [7:0] echo;
    logic [2:0] tag;
    logic       done;
    logic       status;
    logic       secure;
    logic       no_script;
  } tagged_byte_t;

  tagged_byte_t expected_bytes[$];
  int           mismatch_count;

  sch_pkg::phase_e phase_q;
  logic   [3:0]    key_pos_q;
  logic   [2:0]    key_idx_q;
  logic            quoted_q;
  logic            syntax_err_q;
  logic            secure_q;
  logic            no_script_q;

  assign mismatch_o = mismatch_count;

  function automatic string attr_key(input int k);
    case (k)
      sch_pkg::AttrExpires: return "expires=";
      sch_pkg::AttrMaxAge:  return "max-age=";
      sch_pkg::AttrDomain:  return "domain=";
      sch_pkg::AttrPath:    return "path=";
      sch_pkg::AttrSecure:  return "secure";
      default:              return "httponly";
    endcase
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == sch_pkg::ChSpace || c == sch_pkg::ChTab;
  endfunction

  function automatic logic token_char(input logic [7:0] c);
    string punct;
    logic  hit;
    punct = "!#$%&'*+-.^_|~";
    hit = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
          c == 8'h60;
    for (int i = 0; i < punct.len(); i++) begin
      if (c == punct[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Printable ASCII except space, quote, comma, semicolon and backslash.
  function automatic logic value_char(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E && c != sch_pkg::ChQuote && c != "," &&
           c != sch_pkg::ChSemi && c != "\\";
  endfunction

  task automatic clear_parser();
    phase_q      = sch_pkg::PhLead;
    key_pos_q    = '0;
    key_idx_q    = '0;
    quoted_q     = 1'b0;
    syntax_err_q = 1'b0;
    secure_q     = 1'b0;
    no_script_q  = 1'b0;
  endtask

  // A finished value or flag may only be followed by blanks, ';' or the end.
  task automatic close_part(input logic [7:0] c);
    if (blank_char(c)) begin
      phase_q = sch_pkg::PhAfter;
    end else if (c == sch_pkg::ChSemi) begin
      phase_q = sch_pkg::PhAstart;
    end else begin
      syntax_err_q = 1'b1;
    end
  endtask

  task automatic tag_cookie_byte(input logic [7:0] c, input logic last,
                                 output tagged_byte_t r);
    logic [7:0] lc;
    logic [2:0] tag;
    logic       bad;
    string      key;
    int         k;
    int         p;
    lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    tag = sch_pkg::TagSkip;
    if (!syntax_err_q) begin
      case (phase_q)
        sch_pkg::PhLead: begin
          if (token_char(c)) begin
            phase_q = sch_pkg::PhName;
            tag     = sch_pkg::TagName;
          end else if (!blank_char(c)) begin
            syntax_err_q = 1'b1;
          end
        end
        sch_pkg::PhName: begin
          if (token_char(c)) tag = sch_pkg::TagName;
          else if (c == sch_pkg::ChEqual) phase_q = sch_pkg::PhPreval;
          else syntax_err_q = 1'b1;
        end
        sch_pkg::PhPreval: begin
          if (blank_char(c)) begin
          end else if (c == sch_pkg::ChQuote) begin
            quoted_q = 1'b1;
            phase_q  = sch_pkg::PhValue;
          end else if (value_char(c)) begin
            phase_q = sch_pkg::PhValue;
            tag     = sch_pkg::TagValue;
          end else if (c == sch_pkg::ChSemi) begin
            phase_q = sch_pkg::PhAstart;
          end else begin
            syntax_err_q = 1'b1;
          end
        end
        sch_pkg::PhValue: begin
          if (value_char(c)) begin
            tag = sch_pkg::TagValue;
          end else if (quoted_q) begin
            if (c == sch_pkg::ChQuote) begin
              quoted_q = 1'b0;
              phase_q  = sch_pkg::PhAfter;
            end else begin
              syntax_err_q = 1'b1;
            end
          end else begin
            close_part(c);
          end
        end
        sch_pkg::PhAfter: close_part(c);
        sch_pkg::PhAstart: begin
          if (!blank_char(c) && c != sch_pkg::ChSemi) begin
            // The attribute names all start with different letters.
            phase_q = sch_pkg::PhSkip;
            for (int i = 0; i < sch_pkg::NumAttr; i++) begin
              key = attr_key(i);
              if (lc == key[0]) begin
                key_idx_q = i[2:0];
                key_pos_q = 4'd1;
                phase_q   = sch_pkg::PhAmatch;
              end
            end
          end
        end
        sch_pkg::PhAmatch: begin
          k   = (key_idx_q < sch_pkg::NumAttr) ? int'(key_idx_q) : 0;
          key = attr_key(k);
          p   = (key_pos_q < key.len()) ? int'(key_pos_q) : 0;
          if (lc == key[p]) begin
            p++;
            key_pos_q = p[3:0];
            if (p >= key.len()) begin
              if (k == sch_pkg::AttrSecure) begin
                secure_q = 1'b1;
                phase_q  = sch_pkg::PhAfter;
              end else if (k == sch_pkg::AttrHttpOnly) begin
                no_script_q = 1'b1;
                phase_q     = sch_pkg::PhAfter;
              end else begin
                phase_q = sch_pkg::PhAvalue;
              end
            end
          end else begin
            phase_q = (c == sch_pkg::ChSemi) ? sch_pkg::PhAstart : sch_pkg::PhSkip;
          end
        end
        sch_pkg::PhAvalue: begin
          if (c == sch_pkg::ChSemi) phase_q = sch_pkg::PhAstart;
          else tag = sch_pkg::TagExpires +
                     ((key_idx_q < sch_pkg::AttrSecure) ? key_idx_q : sch_pkg::AttrExpires);
        end
        sch_pkg::PhSkip: begin
          if (c == sch_pkg::ChSemi) phase_q = sch_pkg::PhAstart;
        end
        default: syntax_err_q = 1'b1;
      endcase
    end
    r           = '0;
    r.echo      = c;
    r.tag       = syntax_err_q ? sch_pkg::TagSkip : tag;
    r.done      = last;
    if (last) begin
      bad = syntax_err_q || phase_q == sch_pkg::PhLead || phase_q == sch_pkg::PhName ||
            (phase_q == sch_pkg::PhValue && quoted_q) || phase_q > sch_pkg::PhSkip;
      r.status    = bad;
      r.secure    = secure_q;
      r.no_script = no_script_q;
      clear_parser();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tagged_byte_t want;
    tagged_byte_t got;
    if (!rst_ni) begin
      clear_parser();
      expected_bytes.delete();
      mismatch_count = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {echo_byte_i, field_tag_i, done_res_i, status_i, secure_flag_i,
               no_script_flag_i};
        if (expected_bytes.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result beat with nothing expected: byte %h tag %0d done %b",
                     $realtime, echo_byte_i, field_tag_i, done_res_i);
          end
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch byte %h/%h tag %0d/%0d done %b/%b status %b/%b",
                       $realtime, want.echo, got.echo, want.tag, got.tag, want.done,
                       got.done, want.status, got.status);
              $display("  secure %b/%b no_script %b/%b (expected/actual)",
                       want.secure, got.secure, want.no_script, got.no_script);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        tag_cookie_byte(text_byte_i, is_last_i, want);
        expected_bytes.push_back(want);
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-Cookie header parser testbench
// Streams directed and random cookie strings through the parser with random
// gaps and stalls on both channels; a checker beside the block predicts and
// compares every tagged result beat.
// ----------------------------------------------------------------------------
module tb;

  // Longest stretch without any beat on either channel before giving up.
  // The worst correct case is the long consumer hold-off below plus a
  // few random gaps and the input and output registers of the parser.
  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 200;
  localparam int ByteTarget = 1200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] echo_byte;
  logic [2:0] field_tag;
  logic       done_res;
  logic       status;
  logic       secure_flag;
  logic       no_script_flag;

  int         pending;
  int         mismatches;

  // Shared knobs: no_idle turns off the random gaps on both sides, and
  // rx_hold asks the consumer for one long hold-off.
  bit         no_idle = 1'b0;
  bit         rx_hold = 1'b0;
  int         bytes_sent = 0;
  logic [7:0] cookie_text[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  set_cookie_header_parser uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .text_byte_i      (text_byte),
    .is_last_i        (is_last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .echo_byte_o      (echo_byte),
    .field_tag_o      (field_tag),
    .done_res_o       (done_res),
    .status_o         (status),
    .secure_flag_o    (secure_flag),
    .no_script_flag_o (no_script_flag)
  );

  cookie_tag_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .text_byte_i      (text_byte),
    .is_last_i        (is_last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .echo_byte_i      (echo_byte),
    .field_tag_i      (field_tag),
    .done_res_i       (done_res),
    .status_i         (status),
    .secure_flag_i    (secure_flag),
    .no_script_flag_i (no_script_flag),
    .pending_o        (pending),
    .mismatch_o       (mismatches)
  );

  // Offers one beat, after an optional random gap, and returns at the rising
  // edge where it is taken. Ready is sampled at the falling edge, where it is
  // settled, so the decision does not depend on event order at the edge.
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    is_last   <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], i == s.len() - 1);
    end
  endtask

  // Drops valid and waits until the parser has returned every result beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_token();
    string letters;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!#$%&'*+-.^_|~";
    // The backquote is a token character too, but is kept out of the literal.
    if ($urandom_range(0, 15) == 0) return 8'h60;
    return letters[$urandom_range(0, letters.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_value();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E));
    while (c == sch_pkg::ChQuote || c == "," || c == sch_pkg::ChSemi || c == "\\");
    return c;
  endfunction

  function automatic string attr_word(input int k);
    case (k)
      sch_pkg::AttrExpires: return "Expires=";
      sch_pkg::AttrMaxAge:  return "Max-Age=";
      sch_pkg::AttrDomain:  return "Domain=";
      sch_pkg::AttrPath:    return "Path=";
      sch_pkg::AttrSecure:  return "Secure";
      default:              return "HttpOnly";
    endcase
  endfunction

  // Appends the first n characters of a word with each letter's case drawn
  // at random, since attribute names match without regard to case.
  task automatic push_word(input string w, input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = w[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      else if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
      cookie_text.push_back(c);
    end
  endtask

  task automatic push_blank();
    cookie_text.push_back($urandom_range(0, 1) ? sch_pkg::ChSpace : sch_pkg::ChTab);
  endtask

  // Builds one cookie string. Most are well formed with random content so
  // that the attribute states get exercised; some carry a corrupted byte and
  // a few are plain noise over the full byte range.
  task automatic make_cookie();
    logic       quoted;
    string      w;
    int         k;
    logic [7:0] c;
    cookie_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) cookie_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) push_blank();
      repeat ($urandom_range(1, 5)) cookie_text.push_back(pick_token());
      cookie_text.push_back(sch_pkg::ChEqual);
      if ($urandom_range(0, 3) == 0) push_blank();
      quoted = ($urandom_range(0, 3) == 0);
      if (quoted) cookie_text.push_back(sch_pkg::ChQuote);
      repeat ($urandom_range(0, 5)) cookie_text.push_back(pick_value());
      if (quoted) cookie_text.push_back(sch_pkg::ChQuote);
      repeat ($urandom_range(0, 4)) begin
        cookie_text.push_back(sch_pkg::ChSemi);
        if ($urandom_range(0, 1)) push_blank();
        case ($urandom_range(0, 7))
          0, 1, 2, 3: begin
            // Attribute values run to the next ';' and may hold any other byte.
            w = attr_word($urandom_range(sch_pkg::AttrExpires, sch_pkg::AttrPath));
            push_word(w, w.len());
            repeat ($urandom_range(0, 5)) begin
              do c = 8'($urandom_range(0, 255)); while (c == sch_pkg::ChSemi);
              cookie_text.push_back(c);
            end
          end
          4: begin
            w = attr_word(sch_pkg::AttrSecure);
            push_word(w, w.len());
          end
          5: begin
            w = attr_word(sch_pkg::AttrHttpOnly);
            push_word(w, w.len());
          end
          6: begin
            repeat ($urandom_range(1, 4)) cookie_text.push_back(pick_token());
          end
          default: begin
            // A name cut short and continued with other letters is skipped.
            k = $urandom_range(0, sch_pkg::NumAttr - 1);
            w = attr_word(k);
            push_word(w, $urandom_range(1, w.len() - 1));
            repeat ($urandom_range(0, 3)) cookie_text.push_back(pick_token());
          end
        endcase
        if ($urandom_range(0, 5) == 0) push_blank();
      end
      if ($urandom_range(0, 6) == 0) begin
        cookie_text[$urandom_range(0, cookie_text.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  // Consumer: a random hold-off before each result beat, or one long hold-off
  // on request so that the parser fills up and stalls its input.
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        gap     = HoldCycles;
        rx_hold = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: byte zero and byte 255 alone, a quoted value after a
    // leading blank, an unclosed quote, a name without '=', flags in mixed
    // case after an empty value, and a flag followed by a stray character.
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_text(" ~=\"v\"");
    send_text("k=\"v");
    send_text("a");
    send_text("\tb=;SeCuRe");
    send_text("c=;HttpOnlyz");
    send_text("d=e; pAtH=/x;max-age=9;Domain");

    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      if (!held && bytes_sent >= ByteTarget / 3) begin
        // The consumer stalls for a long time while bytes keep coming.
        held    = 1'b1;
        no_idle = 1'b1;
        rx_hold = 1'b1;
      end
      if (!paused && bytes_sent >= 2 * ByteTarget / 3) begin
        paused = 1'b1;
        drain();
      end
      make_cookie();
      for (int i = 0; i < cookie_text.size(); i++) begin
        send_beat(cookie_text[i], i == cookie_text.size() - 1);
      end
    end

    drain();
    // A few extra cycles catch any stray result beat.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
